// ===== rtl/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg: shared types and constants for image difference statistics
// Holds the sample format, the element capacity, the lane result type, the
// totals handed to the finishing unit and its state encoding.
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int MAX_PIXELS_LOG2 = 18;
  localparam int SAMPLE_BITS     = 16;
  localparam int LANES           = 4;

  localparam int CNT_W  = 21;
  localparam int DIFF_W = 16;
  localparam int SQ_W   = 32;
  localparam int SABS_W = 36;
  localparam int SSQ_W  = 52;
  localparam int ROOT_W = SSQ_W / 2;

  localparam logic [CNT_W-1:0] ELEM_CAP = CNT_W'(4 << MAX_PIXELS_LOG2);

  // Per-lane result of one element.
  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic [SQ_W-1:0]   sq;
    logic              mis;
  } lane_out_t;

  // Totals of one image pair, handed over on the last pixel.
  typedef struct packed {
    logic [SABS_W-1:0] sum_abs;
    logic [SSQ_W-1:0]  sum_sq;
    logic [CNT_W-1:0]  divisor;
    logic [CNT_W-1:0]  mis_count;
    logic [CNT_W-1:0]  first_idx;
    logic [DIFF_W-1:0] max_diff;
  } totals_t;

  typedef enum logic [1:0] {
    FIN_IDLE,
    FIN_DIV,
    FIN_SQRT,
    FIN_OUT
  } fin_state_t;

endpackage

// ===== rtl/ids_lane.sv =====
// ----------------------------------------------------------------------------
// ids_lane: one channel lane
// Forms the absolute difference and the mismatch flag in a first stage and
// the square of the difference in a second stage.
// ----------------------------------------------------------------------------
module ids_lane (
  input  logic                       clk,
  input  logic                       en1,
  input  logic                       en2,
  input  logic [15:0]                a,
  input  logic [15:0]                b,
  input  logic [ids_pkg::DIFF_W-1:0] threshold,
  output ids_pkg::lane_out_t         res
);

  logic signed [16:0] sa, sb, d;
  logic [ids_pkg::DIFF_W-1:0] d_abs;
  logic [ids_pkg::DIFF_W-1:0] diff1_r, diff2_r;
  logic mis1_r, mis2_r;
  logic [ids_pkg::SQ_W-1:0] sq_r;

  // Sign-extend the active sample bits and take the absolute difference.
  always_comb begin
    sa = 17'(signed'(a[ids_pkg::SAMPLE_BITS-1:0]));
    sb = 17'(signed'(b[ids_pkg::SAMPLE_BITS-1:0]));
    d = sa - sb;
    d_abs = d[16] ? ids_pkg::DIFF_W'(-d) : ids_pkg::DIFF_W'(d);
  end

  // First stage: difference and mismatch flag.
  always_ff @(posedge clk) begin
    if (en1) begin
      diff1_r <= d_abs;
      mis1_r <= (d_abs > threshold);
    end
  end

  // Second stage: square of the difference.
  always_ff @(posedge clk) begin
    if (en2) begin
      diff2_r <= diff1_r;
      mis2_r <= mis1_r;
      sq_r <= diff1_r * diff1_r;
    end
  end

  assign res.diff = diff2_r;
  assign res.sq = sq_r;
  assign res.mis = mis2_r;

endmodule

// ===== rtl/ids_merge.sv =====
// ----------------------------------------------------------------------------
// ids_merge: merging accumulator
// Folds the four lane results of a pixel into the running statistics up to
// ELEM_CAP; hands the totals over on the last pixel, clearing the statistics.
// ----------------------------------------------------------------------------
module ids_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      valid,
  input  logic                                      last,
  input  ids_pkg::lane_out_t [ids_pkg::LANES-1:0]   lanes,
  output logic                                      done,
  output ids_pkg::totals_t                          totals
);

  logic [ids_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ids_pkg::DIFF_W-1:0] max_r, max_nxt;
  logic [ids_pkg::SABS_W-1:0] sabs_r, sabs_nxt;
  logic [ids_pkg::SSQ_W-1:0]  ssq_r, ssq_nxt;
  logic [ids_pkg::CNT_W-1:0]  mis_r, mis_nxt;
  logic [ids_pkg::CNT_W-1:0]  first_r, first_nxt;
  logic                       found_r, found_nxt;

  // Fold the lanes in channel order so the first mismatch index is exact.
  always_comb begin
    count_nxt = count_r;
    max_nxt = max_r;
    sabs_nxt = sabs_r;
    ssq_nxt = ssq_r;
    mis_nxt = mis_r;
    first_nxt = first_r;
    found_nxt = found_r;
    if (count_r < ids_pkg::ELEM_CAP) begin
      for (int i = 0; i < ids_pkg::LANES; i++) begin
        if (lanes[i].diff > max_nxt) max_nxt = lanes[i].diff;
        sabs_nxt = sabs_nxt + ids_pkg::SABS_W'(lanes[i].diff);
        ssq_nxt = ssq_nxt + ids_pkg::SSQ_W'(lanes[i].sq);
        if (lanes[i].mis) begin
          mis_nxt = mis_nxt + 1'b1;
          if (!found_nxt) begin
            found_nxt = 1'b1;
            first_nxt = count_r + ids_pkg::CNT_W'(i);
          end
        end
      end
      count_nxt = count_r + ids_pkg::CNT_W'(ids_pkg::LANES);
    end
  end

  // Totals seen by the finishing unit on the last pixel.
  always_comb begin
    totals.sum_abs = sabs_nxt;
    totals.sum_sq = ssq_nxt;
    totals.divisor = (count_nxt == '0) ? ids_pkg::CNT_W'(1) : count_nxt;
    totals.mis_count = mis_nxt;
    totals.first_idx = found_nxt ? first_nxt : count_nxt;
    totals.max_diff = max_nxt;
  end

  assign done = valid & last;

  // Statistics registers; cleared after the last pixel.
  always_ff @(posedge clk) begin
    if (!rst_n || (valid && last)) begin
      count_r <= '0;
      max_r <= '0;
      sabs_r <= '0;
      ssq_r <= '0;
      mis_r <= '0;
      first_r <= '0;
      found_r <= 1'b0;
    end else if (valid) begin
      count_r <= count_nxt;
      max_r <= max_nxt;
      sabs_r <= sabs_nxt;
      ssq_r <= ssq_nxt;
      mis_r <= mis_nxt;
      first_r <= first_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

// ===== rtl/ids_finalize.sv =====
// ----------------------------------------------------------------------------
// ids_finalize: mean and root mean square unit
// Divides both sums by the element count one quotient bit per cycle, then
// takes the integer square root two radicand bits per cycle, and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
module ids_finalize (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ids_pkg::totals_t           totals,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [20:0]                out_mismatch_count,
  output logic [20:0]                out_first_mismatch_index,
  output logic [15:0]                out_max_abs_diff,
  output logic [15:0]                out_mean_abs_diff,
  output logic [15:0]                out_rms_error,
  output logic                       out_all_within_threshold
);

  localparam int STEP_W = $clog2(ids_pkg::SSQ_W);

  ids_pkg::fin_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [ids_pkg::SSQ_W-1:0]   qa_r, qs_r;
  logic [ids_pkg::CNT_W-1:0]   ra_r, rs_r, div_r;
  logic [ids_pkg::ROOT_W-1:0]  root_r;
  logic [ids_pkg::ROOT_W+1:0]  rrem_r;
  logic [ids_pkg::CNT_W-1:0]   mis_r, first_r;
  logic [ids_pkg::DIFF_W-1:0]  max_r;

  logic [ids_pkg::CNT_W:0]     ta, ts;
  logic                        ga, gs;
  logic [ids_pkg::ROOT_W+1:0]  sh_rem, trial;
  logic                        gr;

  // One restoring division step on each sum, one square root step.
  always_comb begin
    ta = {ra_r, qa_r[ids_pkg::SSQ_W-1]};
    ts = {rs_r, qs_r[ids_pkg::SSQ_W-1]};
    ga = (ta >= {1'b0, div_r});
    gs = (ts >= {1'b0, div_r});
    sh_rem = {rrem_r[ids_pkg::ROOT_W-1:0], qs_r[ids_pkg::SSQ_W-1 -: 2]};
    trial = {root_r, 2'b01};
    gr = (sh_rem >= trial);
  end

  // Sequencer: next state and step counter.
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    unique case (state_r)
      ids_pkg::FIN_IDLE: begin
        if (start) begin
          state_nxt = ids_pkg::FIN_DIV;
          step_nxt = STEP_W'(ids_pkg::SSQ_W - 1);
        end
      end
      ids_pkg::FIN_DIV: begin
        if (step_r == '0) begin
          state_nxt = ids_pkg::FIN_SQRT;
          step_nxt = STEP_W'(ids_pkg::ROOT_W - 1);
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ids_pkg::FIN_SQRT: begin
        if (step_r == '0) state_nxt = ids_pkg::FIN_OUT;
        else step_nxt = step_r - 1'b1;
      end
      ids_pkg::FIN_OUT: begin
        if (out_ready) state_nxt = ids_pkg::FIN_IDLE;
      end
      default: state_nxt = ids_pkg::FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ids_pkg::FIN_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ids_pkg::FIN_IDLE: begin
        if (start) begin
          qa_r <= ids_pkg::SSQ_W'(totals.sum_abs);
          qs_r <= totals.sum_sq;
          ra_r <= '0;
          rs_r <= '0;
          div_r <= totals.divisor;
          mis_r <= totals.mis_count;
          first_r <= totals.first_idx;
          max_r <= totals.max_diff;
          root_r <= '0;
          rrem_r <= '0;
        end
      end
      ids_pkg::FIN_DIV: begin
        ra_r <= ga ? ids_pkg::CNT_W'(ta - {1'b0, div_r}) : ta[ids_pkg::CNT_W-1:0];
        rs_r <= gs ? ids_pkg::CNT_W'(ts - {1'b0, div_r}) : ts[ids_pkg::CNT_W-1:0];
        qa_r <= {qa_r[ids_pkg::SSQ_W-2:0], ga};
        qs_r <= {qs_r[ids_pkg::SSQ_W-2:0], gs};
      end
      ids_pkg::FIN_SQRT: begin
        rrem_r <= gr ? sh_rem - trial : sh_rem;
        root_r <= {root_r[ids_pkg::ROOT_W-2:0], gr};
        qs_r <= {qs_r[ids_pkg::SSQ_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  // Result item, saturated to the output widths.
  always_comb begin
    out_valid = (state_r == ids_pkg::FIN_OUT);
    out_mismatch_count = mis_r;
    out_first_mismatch_index = first_r;
    out_max_abs_diff = max_r;
    out_mean_abs_diff = (qa_r > ids_pkg::SSQ_W'(16'hFFFF)) ? 16'hFFFF : qa_r[15:0];
    out_rms_error = (root_r > ids_pkg::ROOT_W'(16'hFFFF)) ? 16'hFFFF : root_r[15:0];
    out_all_within_threshold = (mis_r == '0);
  end

endmodule

// ===== rtl/image_difference_statistics.sv =====
// ----------------------------------------------------------------------------
// image_difference_statistics: top level
// Pixels are accepted one per cycle while the block is not busy, and pass
// through the lane stages into the statistics registers. The last pixel
// starts the division and then the square root, and no further pixel is
// accepted until the result item is taken. Synchronous active-low reset
// clears the statistics, the threshold and the sequencer.
// ----------------------------------------------------------------------------
module image_difference_statistics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_a_red,
  input  logic [15:0] in_a_green,
  input  logic [15:0] in_a_blue,
  input  logic [15:0] in_a_alpha,
  input  logic [15:0] in_b_red,
  input  logic [15:0] in_b_green,
  input  logic [15:0] in_b_blue,
  input  logic [15:0] in_b_alpha,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_mismatch_count,
  output logic [20:0] out_first_mismatch_index,
  output logic [15:0] out_max_abs_diff,
  output logic [15:0] out_mean_abs_diff,
  output logic [15:0] out_rms_error,
  output logic        out_all_within_threshold
);

  logic [15:0] threshold_r;
  logic busy_r;
  logic v1_r, v2_r, last1_r, last2_r;
  logic accept_in;
  logic [15:0] a_s [ids_pkg::LANES];
  logic [15:0] b_s [ids_pkg::LANES];
  ids_pkg::lane_out_t [ids_pkg::LANES-1:0] lanes;
  ids_pkg::totals_t totals;
  logic done;

  assign accept_in = in_valid & in_ready;
  assign in_ready = ~busy_r;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) threshold_r <= '0;
    else if (cfg_we) threshold_r <= cfg_wdata;
  end

  // Busy from the last pixel's acceptance until its result item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      last1_r <= 1'b0;
      last2_r <= 1'b0;
    end else begin
      if (accept_in && in_last_pixel) busy_r <= 1'b1;
      else if (out_valid && out_ready) busy_r <= 1'b0;
      v1_r <= accept_in;
      v2_r <= v1_r;
      if (accept_in) last1_r <= in_last_pixel;
      if (v1_r) last2_r <= last1_r;
    end
  end

  assign a_s[0] = in_a_red;
  assign a_s[1] = in_a_green;
  assign a_s[2] = in_a_blue;
  assign a_s[3] = in_a_alpha;
  assign b_s[0] = in_b_red;
  assign b_s[1] = in_b_green;
  assign b_s[2] = in_b_blue;
  assign b_s[3] = in_b_alpha;

  // Channel lanes, red first.
  for (genvar i = 0; i < ids_pkg::LANES; i++) begin : g_lane
    ids_lane u_lane (
      .clk       (clk),
      .en1       (accept_in),
      .en2       (v1_r),
      .a         (a_s[i]),
      .b         (b_s[i]),
      .threshold (threshold_r),
      .res       (lanes[i])
    );
  end

  ids_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (v2_r),
    .last   (last2_r),
    .lanes  (lanes),
    .done   (done),
    .totals (totals)
  );

  ids_finalize u_fin (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (done),
    .totals                   (totals),
    .out_ready                (out_ready),
    .out_valid                (out_valid),
    .out_mismatch_count       (out_mismatch_count),
    .out_first_mismatch_index (out_first_mismatch_index),
    .out_max_abs_diff         (out_max_abs_diff),
    .out_mean_abs_diff        (out_mean_abs_diff),
    .out_rms_error            (out_rms_error),
    .out_all_within_threshold (out_all_within_threshold)
  );

  // A pending result item always holds off new pixels.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("pixel accepted while a result item is pending");

  // Totals are handed over only while the block is busy.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r)
    else $error("totals handed over while not busy");

  // Taking the result item frees the input next cycle.
  a_free_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("input not freed after result item taken");

endmodule

// ===== tb/image_difference_statistics_checker.sv =====
// ----------------------------------------------------------------------------
// image_difference_statistics_checker: result predictor and comparator
// Watches the pixel and result channels and the threshold port, keeps its own
// copy of the image statistics, and compares every result item against the
// oldest predicted one.
// ----------------------------------------------------------------------------
module image_difference_statistics_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_a_red,
  input  logic [15:0] in_a_green,
  input  logic [15:0] in_a_blue,
  input  logic [15:0] in_a_alpha,
  input  logic [15:0] in_b_red,
  input  logic [15:0] in_b_green,
  input  logic [15:0] in_b_blue,
  input  logic [15:0] in_b_alpha,
  input  logic        in_last_pixel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [20:0] out_mismatch_count,
  input  logic [20:0] out_first_mismatch_index,
  input  logic [15:0] out_max_abs_diff,
  input  logic [15:0] out_mean_abs_diff,
  input  logic [15:0] out_rms_error,
  input  logic        out_all_within_threshold,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [20:0] mis_count;
    logic [20:0] first_idx;
    logic [15:0] max_diff;
    logic [15:0] mean_diff;
    logic [15:0] rms;
    logic        all_within;
  } image_stats_t;

  image_stats_t stats_queue[$];

  logic [15:0] threshold;
  logic [20:0] elem_count;
  logic [15:0] run_max;
  logic [35:0] abs_sum;
  logic [51:0] sq_sum;
  logic [20:0] mis_seen;
  logic [20:0] first_seen;
  logic        found;

  // Integer square root by the bitwise restoring method.
  function automatic logic [31:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // Fold one accepted pixel into the statistics; queue a result on the last.
  task automatic absorb_pixel();
    logic signed [16:0] d;
    logic [15:0] diff;
    logic [15:0] a_s [4];
    logic [15:0] b_s [4];
    logic [63:0] n;
    logic [63:0] mean;
    logic [31:0] root;
    image_stats_t r;
    a_s = '{in_a_red, in_a_green, in_a_blue, in_a_alpha};
    b_s = '{in_b_red, in_b_green, in_b_blue, in_b_alpha};
    if (elem_count < ids_pkg::ELEM_CAP) begin
      for (int ch = 0; ch < 4; ch++) begin
        d = $signed({a_s[ch][15], a_s[ch]}) - $signed({b_s[ch][15], b_s[ch]});
        diff = d < 0 ? 16'(-d) : 16'(d);
        if (diff > run_max) run_max = diff;
        abs_sum += 36'(diff);
        sq_sum += 52'(32'(diff) * 32'(diff));
        if (diff > threshold) begin
          mis_seen++;
          if (!found) begin
            found = 1'b1;
            first_seen = elem_count + 21'(ch);
          end
        end
      end
      elem_count += 21'd4;
    end
    if (in_last_pixel) begin
      n = elem_count != 0 ? 64'(elem_count) : 64'd1;
      mean = 64'(abs_sum) / n;
      root = int_sqrt(64'(sq_sum) / n);
      r.mis_count = mis_seen;
      r.first_idx = found ? first_seen : elem_count;
      r.max_diff = run_max;
      r.mean_diff = mean > 64'hFFFF ? 16'hFFFF : mean[15:0];
      r.rms = root > 32'hFFFF ? 16'hFFFF : root[15:0];
      r.all_within = mis_seen == 0;
      stats_queue.insert(stats_queue.size(), r);
      elem_count = 0; run_max = 0; abs_sum = 0; sq_sum = 0;
      mis_seen = 0; first_seen = 0; found = 0;
    end
  endtask

  // Compare one field and report a mismatch.
  task automatic check_field(string name, logic [20:0] exp_v, logic [20:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Watch the channels at every rising edge.
  always @(posedge clk) begin
    image_stats_t e;
    if (!rst_n) begin
      threshold = 0;
      elem_count = 0; run_max = 0; abs_sum = 0; sq_sum = 0;
      mis_seen = 0; first_seen = 0; found = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (stats_queue.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual count %0d",
                   $time, out_mismatch_count);
          fail_count++;
        end else begin
          e = stats_queue.pop_front();
          check_field("mismatch_count", e.mis_count, out_mismatch_count);
          check_field("first_mismatch_index", e.first_idx, out_first_mismatch_index);
          check_field("max_abs_diff", 21'(e.max_diff), 21'(out_max_abs_diff));
          check_field("mean_abs_diff", 21'(e.mean_diff), 21'(out_mean_abs_diff));
          check_field("rms_error", 21'(e.rms), 21'(out_rms_error));
          check_field("all_within_threshold", 21'(e.all_within),
                      21'(out_all_within_threshold));
        end
      end
      // The pixel sees the threshold held before this edge's write.
      if (in_valid && in_ready) absorb_pixel();
      if (cfg_we) threshold = cfg_wdata;
    end
    pending_count = stats_queue.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
  end
endmodule

// ===== tb/tb_image_difference_statistics.sv =====
// ----------------------------------------------------------------------------
// tb_image_difference_statistics: regression for image difference statistics
// Streams directed and random image pairs under several thresholds with
// random gaps on both channels; a checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_image_difference_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_a_red, in_a_green, in_a_blue, in_a_alpha;
  logic [15:0] in_b_red, in_b_green, in_b_blue, in_b_alpha;
  logic        in_last_pixel;
  logic        out_valid;
  logic        out_ready;
  logic [20:0] out_mismatch_count;
  logic [20:0] out_first_mismatch_index;
  logic [15:0] out_max_abs_diff;
  logic [15:0] out_mean_abs_diff;
  logic [15:0] out_rms_error;
  logic        out_all_within_threshold;
  int          fail_count;
  int          pending_count;
  int          cycle_count;
  bit          calm_phase;

  image_difference_statistics u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_red(in_a_red), .in_a_green(in_a_green), .in_a_blue(in_a_blue),
    .in_a_alpha(in_a_alpha), .in_b_red(in_b_red), .in_b_green(in_b_green),
    .in_b_blue(in_b_blue), .in_b_alpha(in_b_alpha), .in_last_pixel(in_last_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_mismatch_count(out_mismatch_count),
    .out_first_mismatch_index(out_first_mismatch_index),
    .out_max_abs_diff(out_max_abs_diff), .out_mean_abs_diff(out_mean_abs_diff),
    .out_rms_error(out_rms_error), .out_all_within_threshold(out_all_within_threshold)
  );

  image_difference_statistics_checker u_checker (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with the run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("image_difference_statistics regression: fail");
        $finish;
      end
    end
  end

  // Result side stalls at random except in the calm phase.
  always @(posedge clk) begin
    out_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // Send one pixel, with an optional random gap first; valid stays high
  // into the next item when there is no gap.
  task automatic send_pixel(logic [15:0] a[4], logic [15:0] b[4], logic last);
    while (!calm_phase && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_a_red, in_a_green, in_a_blue, in_a_alpha} <= {a[0], a[1], a[2], a[3]};
    {in_b_red, in_b_green, in_b_blue, in_b_alpha} <= {b[0], b[1], b[2], b[3]};
    in_last_pixel <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random pixel; small differences often so the threshold matters.
  task automatic send_random(logic last);
    logic [15:0] a[4];
    logic [15:0] b[4];
    for (int i = 0; i < 4; i++) begin
      a[i] = 16'($urandom);
      case ($urandom_range(3))
        0: b[i] = 16'($urandom);
        1: b[i] = a[i];
        2: b[i] = a[i] + 16'($urandom_range(64)) - 16'd32;
        default: b[i] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      endcase
    end
    send_pixel(a, b, last);
  endtask

  // Wait for all results, then settle before a threshold write.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] a[4];
    logic [15:0] b[4];
    logic [15:0] thresholds[5];
    int len;
    thresholds = '{16'd0, 16'hFFFF, 16'd16, 16'd4096, 16'd1000};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_last_pixel = 1'b0;
    {in_a_red, in_a_green, in_a_blue, in_a_alpha} = '0;
    {in_b_red, in_b_green, in_b_blue, in_b_alpha} = '0;
    out_ready = 1'b0;
    calm_phase = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identical pixels at reset threshold, then extremes.
    a = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    send_pixel(a, a, 1'b1);
    b = '{16'h8000, 16'h8000, 16'h7FFF, 16'h0001};
    send_pixel(a, b, 1'b0);
    send_pixel('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
               '{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1);
    send_pixel('{16'h0001, 16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0, 16'h0}, 1'b0);
    send_pixel('{16'h0, 16'h0, 16'h0, 16'h5555}, '{16'h0, 16'h0, 16'h0, 16'hAAAA}, 1'b1);
    drain();

    // Random images across threshold settings; one phase without stalls.
    for (int p = 0; p < 5; p++) begin
      write_threshold(thresholds[p]);
      calm_phase = (p == 2);
      // Largest difference, in every phase; at the maximum threshold no element can exceed it, check index = count.
      send_pixel('{16'h7FFF, 16'h0, 16'h0, 16'h0}, '{16'h8000, 16'h0, 16'h0, 16'h0}, 1'b1);
      for (int img = 0; img < 20; img++) begin
        len = $urandom_range(12) == 0 ? $urandom_range(60, 100) : $urandom_range(1, 20);
        for (int k = 0; k < len; k++) send_random(k == len - 1);
      end
      drain();
    end
    calm_phase = 1'b0;

    if (fail_count == 0) begin
      $display("image_difference_statistics regression: pass");
    end else begin
      $display("image_difference_statistics regression: fail");
    end
    $finish;
  end
endmodule
